// File: src/frame_rate_meter_unit_assert.svh
// Assertion macros shared by the frame rate meter RTL.
// Included by modules that check their own sequencing; no other dependencies.
`ifndef FRAME_RATE_METER_UNIT_ASSERT_SVH
`define FRAME_RATE_METER_UNIT_ASSERT_SVH
`ifndef SYNTH
// Check a property on every clock edge outside reset.
`define FRMU_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition never holds outside reset.
`define FRMU_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define FRMU_ASSERT(lbl, clk, rst_n, prop, msg)
`define FRMU_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// File: src/frmu_pkg.sv
// Package for the frame rate meter: field widths, rate constants and the
// control/status structs between the sequencer and the divider.
`timescale 1ns / 1ps
package frmu_pkg;

  localparam int unsigned FRMU_STAMP_W     = 32;
  localparam int unsigned FRMU_SUM_W       = 32;
  localparam int unsigned FRMU_RATE_W      = 18;
  localparam int unsigned FRMU_DIV_W       = 32;
  localparam int unsigned FRMU_SHIFT_DEF   = 4;
  localparam int unsigned FRMU_OUT_TDATA_W = 56;

  localparam logic [FRMU_RATE_W-1:0] FRMU_IDLE_RATE  = 18'd600;
  localparam logic [FRMU_RATE_W-1:0] FRMU_RATE_MAX   = 18'h3FFFF;
  localparam logic [FRMU_DIV_W-1:0]  FRMU_RATE_SCALE = 32'd10000;

  // Sequencer to divider
  typedef struct packed {
    logic start;
  } div_ctl_t;

  // Divider to sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

// File: src/frame_rate_meter_unit.sv
// Frame rate meter: smoothed period sum and frame rate in tenths per second.
// Each accepted word passes through the update, divider start, 32 divider steps,
// done handoff and result load before out_tvalid; sum of zero skips the divide.
// A new word is taken only once the last result is loaded into the output slot.
// Reset (synchronous, rst_n low): stored stamp and period sum clear to zero.
// Depends on frmu_pkg, frmu_div and the assertion macro header.
`timescale 1ns / 1ps
`include "frame_rate_meter_unit_assert.svh"
module frame_rate_meter_unit import frmu_pkg::*; #(
  parameter int unsigned SMOOTH_SHIFT = FRMU_SHIFT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [FRMU_STAMP_W-1:0]     in_tdata,   // [31:0] now_ms
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [FRMU_OUT_TDATA_W-1:0] out_tdata   // [17:0] fps_tenths, [49:18] smoothed_period
);

  localparam logic [FRMU_DIV_W-1:0] DIVIDEND = FRMU_RATE_SCALE << SMOOTH_SHIFT;
  localparam int unsigned PAD_W = FRMU_OUT_TDATA_W - FRMU_RATE_W - FRMU_SUM_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_DIV_GO,
    S_DIV_WAIT,
    S_EMIT
  } state_t;

  state_t                  state_r;
  logic [FRMU_STAMP_W-1:0] prev_r;
  logic [FRMU_SUM_W-1:0]   sum_r;
  logic [FRMU_SUM_W-1:0]   period_r;
  logic [FRMU_SUM_W-1:0]   decay_r;
  logic                    have_prev_r;
  logic                    out_valid_r;
  logic [FRMU_RATE_W-1:0]  out_rate_r;
  logic [FRMU_SUM_W-1:0]   out_sum_r;

  logic                    in_acc;
  logic                    slot_free;
  logic [FRMU_RATE_W-1:0]  rate_nxt;
  div_ctl_t                div_ctl;
  div_sts_t                div_sts;
  logic [FRMU_DIV_W-1:0]   quotient;

  assign in_acc    = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);

  // Pick the idle rate, the saturated quotient, or the quotient itself
  always_comb begin
    if (sum_r == '0) begin
      rate_nxt = FRMU_IDLE_RATE;
    end else if (quotient[FRMU_DIV_W-1:FRMU_RATE_W] != '0) begin
      rate_nxt = FRMU_RATE_MAX;
    end else begin
      rate_nxt = quotient[FRMU_RATE_W-1:0];
    end
  end

  assign div_ctl.start = (state_r == S_DIV_GO) && (sum_r != '0);

  // Sequence one word: decay and period, update, divide, emit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      prev_r      <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Load a new word into the output slot, or drop the one just taken
      if (state_r == S_EMIT && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            period_r    <= in_tdata - prev_r;
            decay_r     <= sum_r - (sum_r >> SMOOTH_SHIFT);
            have_prev_r <= (prev_r != '0);
            prev_r      <= in_tdata;
            state_r     <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (have_prev_r) begin
            sum_r <= decay_r + period_r;
          end
          state_r <= S_DIV_GO;
        end
        S_DIV_GO: begin
          state_r <= (sum_r == '0) ? S_EMIT : S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_sts.done) begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            out_rate_r  <= rate_nxt;
            out_sum_r   <= sum_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  frmu_div #(
    .W (FRMU_DIV_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (DIVIDEND),
    .divisor  (sum_r),
    .quotient (quotient),
    .sts      (div_sts)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_sum_r, out_rate_r};

  `FRMU_ASSERT(a_busy_after_accept, clk, rst_n, in_acc |=> !in_tready, "ready right after accepting a word")
  `FRMU_NEVER(a_no_zero_divide, clk, rst_n, div_ctl.start && sum_r == '0, "divide started on a zero sum")
  `FRMU_ASSERT(a_done_expected, clk, rst_n, div_sts.done |-> state_r == S_DIV_WAIT, "divider finished with no word waiting")

endmodule

// File: src/frmu_div.sv
// Restoring divider: one quotient bit per cycle.
// Depends on frmu_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "frame_rate_meter_unit_assert.svh"
module frmu_div import frmu_pkg::*; #(
  parameter int unsigned W = FRMU_DIV_W
) (
  input  logic         clk,
  input  logic         rst_n,
  input  div_ctl_t     ctl,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic [W-1:0] quotient,
  output div_sts_t     sts
);

  localparam int unsigned CW = $clog2(W);

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  state_t        state_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  rem_r;
  logic [W-1:0]  quo_r;
  logic          done_r;

  logic [W:0]    trial;
  logic [W:0]    diff;
  logic          take;

  // Shift in the next dividend bit and try the subtract
  always_comb begin
    trial = {rem_r, quo_r[W-1]};
    diff  = trial - {1'b0, divisor};
    take  = ~diff[W];
  end

  // Step the divide one bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          done_r <= 1'b0;
          if (ctl.start) begin
            rem_r   <= '0;
            quo_r   <= dividend;
            cnt_r   <= CW'(W - 1);
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          rem_r <= take ? diff[W-1:0] : trial[W-1:0];
          quo_r <= {quo_r[W-2:0], take};
          if (cnt_r == '0) begin
            done_r  <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        default: begin
          state_r <= S_IDLE;
          done_r  <= 1'b0;
        end
      endcase
    end
  end

  assign quotient = quo_r;
  assign sts.busy = (state_r == S_RUN);
  assign sts.done = done_r;

  `FRMU_ASSERT(a_start_runs, clk, rst_n, (ctl.start && state_r == S_IDLE) |=> sts.busy, "divider did not start")
  `FRMU_NEVER(a_done_idle, clk, rst_n, sts.done && sts.busy, "done while still running")
  `FRMU_NEVER(a_no_restart, clk, rst_n, ctl.start && sts.busy, "start while busy")

endmodule
